// ===== sv/lfp_pkg.sv =====
// Shared types and constants for the lidar frame parser.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package lfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int DIST_W      = 17;
    localparam int STR_W       = 16;
    localparam int RAW_W       = 16;
    localparam int POS_W       = 4;
    localparam int FRAME_BYTES = 9;

    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;

    // Register byte addresses on the configuration port
    localparam logic [APB_ADDR_W-1:0] REG_HEADER_ADDR = APB_ADDR_W'(0);

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h59;

    // Frame positions: which byte of the frame is expected next
    localparam logic [POS_W-1:0] POS_HUNT    = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR2    = 4'd1;
    localparam logic [POS_W-1:0] POS_DIST_LO = 4'd2;
    localparam logic [POS_W-1:0] POS_DIST_HI = 4'd3;
    localparam logic [POS_W-1:0] POS_STR_LO  = 4'd4;
    localparam logic [POS_W-1:0] POS_STR_HI  = 4'd5;
    localparam logic [POS_W-1:0] POS_CSUM    = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_END     = POS_W'(FRAME_BYTES);

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [STR_W-1:0]  strength;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/lfp_if.sv =====
// Valid/ready channel interfaces for received bytes and parsed results.
// Depends on lfp_pkg for field widths.
`default_nettype none

interface lfp_rx_if;
    logic                       valid;
    logic                       ready;
    logic [lfp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfp_res_if;
    logic                       valid;
    logic                       ready;
    logic [lfp_pkg::DIST_W-1:0] distance;
    logic [lfp_pkg::STR_W-1:0]  strength;

    modport source (output valid, output distance, output strength, input ready);
    modport sink   (input valid, input distance, input strength, output ready);
endinterface

`default_nettype wire

// ===== sv/lfp_apb_regs.sv =====
// APB-style configuration register: holds the frame header byte.
// Depends on lfp_pkg for widths, address map and reset value.
`default_nettype none

module lfp_apb_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lfp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lfp_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lfp_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output logic      [lfp_pkg::BYTE_W-1:0]     o_header
);

    logic r_unused;
    logic wr_en;

    // Single word register: every byte address decodes to it
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_header <= lfp_pkg::HEADER_RESET;
        end else if (wr_en) begin
            o_header <= pwdata[lfp_pkg::BYTE_W-1:0];
        end
    end

    // Fold the upper data bits and address into a sink flop
    always_ff @(posedge i_clk) begin
        r_unused <= ^{pwdata[lfp_pkg::APB_DATA_W-1:lfp_pkg::BYTE_W],
                      paddr == lfp_pkg::REG_HEADER_ADDR};
    end

    assign prdata = {{(lfp_pkg::APB_DATA_W-lfp_pkg::BYTE_W){r_unused & 1'b0}}, o_header};

endmodule

`default_nettype wire

// ===== sv/lfp_frame_core.sv =====
// Frame state tracker: header hunt, field capture, running checksum.
// Depends on lfp_pkg for positions, widths and the result struct.
`default_nettype none

module lfp_frame_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [lfp_pkg::BYTE_W-1:0] i_byte,
    input  wire logic [lfp_pkg::BYTE_W-1:0] i_header,
    output logic                            o_hit,
    output lfp_pkg::t_result                o_result
);

    logic [lfp_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [lfp_pkg::BYTE_W-1:0] r_sum, n_sum;
    logic [lfp_pkg::RAW_W-1:0]  r_dist, n_dist;
    logic [lfp_pkg::RAW_W-1:0]  r_str, n_str;
    logic                       hdr_match;

    assign hdr_match = (i_byte == i_header);

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_dist = r_dist;
        n_str  = r_str;
        o_hit  = 1'b0;
        if (i_step) begin
            priority if (r_pos == lfp_pkg::POS_HUNT || r_pos >= lfp_pkg::POS_END) begin
                n_pos = hdr_match ? lfp_pkg::POS_HDR2 : lfp_pkg::POS_HUNT;
                if (hdr_match) begin
                    n_sum = i_byte;
                end
            end else if (r_pos == lfp_pkg::POS_HDR2) begin
                // Drop the frame unless this byte is a second header
                n_pos = hdr_match ? lfp_pkg::POS_DIST_LO : lfp_pkg::POS_HUNT;
                if (hdr_match) begin
                    n_sum = r_sum + i_byte;
                end
            end else if (r_pos == lfp_pkg::POS_CSUM) begin
                n_pos = lfp_pkg::POS_HUNT;
                o_hit = (i_byte == r_sum);
            end else begin
                unique case (r_pos)
                    lfp_pkg::POS_DIST_LO: n_dist = {r_dist[15:8], i_byte};
                    lfp_pkg::POS_DIST_HI: n_dist = {i_byte, r_dist[7:0]};
                    lfp_pkg::POS_STR_LO:  n_str  = {r_str[15:8], i_byte};
                    lfp_pkg::POS_STR_HI:  n_str  = {i_byte, r_str[7:0]};
                    default: ;
                endcase
                n_sum = r_sum + i_byte;
                n_pos = r_pos + lfp_pkg::POS_W'(1);
            end
        end
    end

    assign o_result.distance = {1'b0, r_dist} + lfp_pkg::DIST_W'(1);
    assign o_result.strength = r_str;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= lfp_pkg::POS_HUNT;
            r_sum  <= '0;
            r_dist <= '0;
            r_str  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_dist <= n_dist;
            r_str  <= n_str;
        end
    end

    // Position never leaves the frame range
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < lfp_pkg::POS_END)
        else $error("frame position out of range");

    // A result only comes from a checksum byte
    a_hit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> (i_step && r_pos == lfp_pkg::POS_CSUM))
        else $error("result outside checksum byte");

    // A non-header second byte returns to hunting
    a_hdr2_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_pos == lfp_pkg::POS_HDR2 && !hdr_match) |=> r_pos == lfp_pkg::POS_HUNT)
        else $error("bad second header not dropped");

endmodule

`default_nettype wire

// ===== sv/lidar_frame_parser_unit.sv =====
// Lidar frame parser top level: byte input register, frame core, result register, APB port.
// Flow: a transferred byte is held in the input register until the core parses it; its result is registered after it.
// Throughput: one byte per cycle while the result register is free or draining; a waiting result stalls input.
// Reset: synchronous active-low; position, checksum and fields clear, header returns to 0x59.
// Depends on lfp_pkg, lfp_if, lfp_apb_regs and lfp_frame_core.
`default_nettype none

module lidar_frame_parser_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    lfp_rx_if.sink                              i_rx,
    lfp_res_if.source                           o_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lfp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lfp_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lfp_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    logic [lfp_pkg::BYTE_W-1:0] header;

    // Input register stage
    logic                       r_in_vld;
    logic [lfp_pkg::BYTE_W-1:0] r_in_byte;

    // Result register stage
    logic                       r_out_vld;
    lfp_pkg::t_result           r_out;

    logic                       step;
    logic                       in_xfer;
    logic                       hit;
    lfp_pkg::t_result           result;

    lfp_apb_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_header (header)
    );

    // Advance the held byte whenever the result register is free or draining
    assign step       = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_rx.ready = !r_in_vld || step;
    assign in_xfer    = i_rx.valid && i_rx.ready;

    lfp_frame_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_header (header),
        .o_hit    (hit),
        .o_result (result)
    );

    // Capture each transferred byte; hold it until the core takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Load a result on a checksum match; drop valid once the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step && hit) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && hit) begin
            r_out <= result;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.distance = r_out.distance;
    assign o_res.strength = r_out.strength;

    // A waiting result is never overwritten by the core
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready) |-> !step)
        else $error("result register overrun");

    // A held byte stays put until the core takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !step) |=> (r_in_vld && $stable(r_in_byte)))
        else $error("held input byte changed");

    // A waiting result stays put until the sink takes it
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready) |=> (r_out_vld && $stable(r_out)))
        else $error("waiting result changed");

endmodule

`default_nettype wire
